/* rtl/i2c_register_transfer_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// i2c register transfer sequencer assertion macros
// immediate-free concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define IRTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define IRTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IRTS_ASSERT_IMP(lbl, ante, cons, msg)
`define IRTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/irts_pkg.sv */
// ----------------------------------------------------------------------------
// irts_pkg
// types, codes and constants shared by the i2c register transfer sequencer
// ----------------------------------------------------------------------------
package irts_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned MAX_RESULTS = 4;
	localparam logic [7:0] TIMEOUT_RESET = 8'd25;

	typedef enum logic [1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_WDATA  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START1 = 4'd1,
		PH_ADDR1  = 4'd2,
		PH_REG    = 4'd3,
		PH_START2 = 4'd4,
		PH_ADDR2  = 4'd5,
		PH_RX     = 4'd6,
		PH_DATA   = 4'd7,
		PH_TXE    = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		A_START    = 4'd0,
		A_TX       = 4'd1,
		A_STOP     = 4'd2,
		A_BUSRESET = 4'd3,
		A_ACK      = 4'd4,
		A_NACK     = 4'd5,
		A_CLRARB   = 4'd6,
		A_CLRADDR  = 4'd7,
		A_REQ      = 4'd8,
		A_READ     = 4'd9,
		A_DONE     = 4'd10
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BUSERR  = 3'd1,
		ST_NACK    = 3'd2,
		ST_ARBLOST = 3'd3,
		ST_TIMEOUT = 3'd4
	} stat_t;

	// status flag bit positions
	localparam int unsigned F_START  = 0;
	localparam int unsigned F_ADDR   = 1;
	localparam int unsigned F_TXE    = 2;
	localparam int unsigned F_RXNE   = 3;
	localparam int unsigned F_BUSERR = 4;
	localparam int unsigned F_NACK   = 5;
	localparam int unsigned F_ARB    = 6;

	typedef struct packed {
		action_t    action;
		logic [7:0] value;
		logic [7:0] index;
		stat_t      status;
	} result_t;

	typedef struct packed {
		logic [2:0]                      count;
		result_t [MAX_RESULTS-1:0]       res;
	} bundle_t;

	function automatic result_t mk_res(action_t a, logic [7:0] v, logic [7:0] i, stat_t s);
		result_t r;
		r.action = a;
		r.value  = v;
		r.index  = i;
		r.status = s;
		return r;
	endfunction

endpackage

/* rtl/i2c_register_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer
// drives an i2c master peripheral through one register write or read
//
// channel   dir  beat
// s_axis    in   tuser: command[1:0]; tdata: is_read, target, register, count,
//                status flags, data byte
// m_axis    out  tuser: action[3:0]; tdata: byte_value, byte_index,
//                completion_status; tlast on final result of an input beat
// cfg       in   cfg_data: timeout_ticks
//
// one input beat accepted per cycle while the bundle queue has room
// each beat yields 0 to 4 output beats, one per cycle while m_axis is ready
// sequencer state updates at the accepting edge, the first result beat is
// valid after the next edge at the earliest, when the output side is idle,
// later while it is still sending older beats
// async reset clears all control state, timeout_ticks resets to 25
// ----------------------------------------------------------------------------
`include "i2c_register_transfer_sequencer_macros.svh"

module i2c_register_transfer_sequencer import irts_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// is_read, target_address, register_byte, byte_count, status_flags, data_byte
	input  logic [39:0] s_axis_tdata,
	// command
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// byte_value, byte_index, completion_status
	output logic [23:0] m_axis_tdata,
	// action
	output logic [3:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic                       push;
	bundle_t                    push_data;
	logic                       q_full;
	logic                       pop;
	bundle_t                    pop_data;
	logic                       q_empty;
	logic [$clog2(Depth+1)-1:0] q_count;
	logic                       front_idle;

	irts_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.push          (push),
		.push_data     (push_data),
		.q_full        (q_full),
		.idle          (front_idle)
	);

	irts_queue #(
		.Depth (Depth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.count     (q_count)
	);

	irts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_data      (pop_data),
		.q_empty       (q_empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	`IRTS_ASSERT_IMP(a_done_is_last, m_axis_tvalid && (m_axis_tuser == A_DONE), m_axis_tlast, "done beat without tlast")
	`IRTS_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= ($clog2(Depth+1))'(Depth), "queue count over depth")
	`IRTS_ASSERT_NXT(a_begin_result, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_BEGIN) && front_idle, !q_empty || m_axis_tvalid, "begin beat left no result")

endmodule

/* rtl/irts_front.sv */
// ----------------------------------------------------------------------------
// irts_front
// accepts input beats, runs the transaction sequencer and packs results
// ----------------------------------------------------------------------------
module irts_front import irts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        push,
	output bundle_t     push_data,
	input  logic        q_full,
	output logic        idle
);

	logic       in_is_read;
	logic [6:0] in_target;
	logic [7:0] in_register;
	logic [7:0] in_count;
	logic [6:0] in_flags;
	logic [7:0] in_data;
	cmd_t       in_cmd;

	phase_t     phase_q, nxt_phase;
	logic [7:0] cd_q, nxt_cd;
	logic [7:0] bl_q, nxt_bl;
	logic [6:0] tgt_q, nxt_tgt;
	logic [7:0] reg_q, nxt_reg;
	logic       rd_q, nxt_rd;
	logic [7:0] timeout_q;
	logic [7:0] bl_dec;
	logic       okbit;
	logic       accept;
	bundle_t    b;

	assign in_is_read  = s_axis_tdata[0];
	assign in_target   = s_axis_tdata[7:1];
	assign in_register = s_axis_tdata[15:8];
	assign in_count    = s_axis_tdata[23:16];
	assign in_flags    = s_axis_tdata[30:24];
	assign in_data     = s_axis_tdata[38:31];
	assign in_cmd      = cmd_t'(s_axis_tuser);

	assign s_axis_tready = !q_full;
	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign bl_dec        = bl_q - 8'd1;
	assign idle          = (phase_q == PH_IDLE);

	always_comb begin
		nxt_phase = phase_q;
		nxt_cd    = cd_q;
		nxt_bl    = bl_q;
		nxt_tgt   = tgt_q;
		nxt_reg   = reg_q;
		nxt_rd    = rd_q;
		b         = '0;
		okbit     = (phase_q == PH_ADDR1 || phase_q == PH_ADDR2) ? in_flags[F_ADDR]
			: in_flags[F_TXE];
		case (in_cmd)
			CMD_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					nxt_rd    = in_is_read;
					nxt_tgt   = in_target;
					nxt_reg   = in_register;
					nxt_bl    = in_count;
					b.count   = 3'd1;
					b.res[0]  = mk_res(A_START, 8'd0, 8'd0, ST_OK);
					nxt_phase = PH_START1;
					nxt_cd    = timeout_q;
				end
			end
			CMD_SAMPLE: begin
				case (phase_q)
					PH_START1, PH_START2: begin
						if (in_flags[F_START]) begin
							b.count  = 3'd1;
							b.res[0] = mk_res(A_TX, {tgt_q, phase_q == PH_START2}, 8'd0, ST_OK);
							nxt_phase = (phase_q == PH_START2) ? PH_ADDR2 : PH_ADDR1;
							nxt_cd   = timeout_q;
						end
					end
					PH_ADDR1, PH_REG, PH_TXE, PH_ADDR2: begin
						if (in_flags[F_BUSERR]) begin
							b.count   = 3'd1;
							b.res[0]  = mk_res(A_DONE, 8'd0, 8'd0, ST_BUSERR);
							nxt_phase = PH_IDLE;
						end else if (in_flags[F_NACK]) begin
							b.count   = 3'd2;
							b.res[0]  = mk_res(A_STOP, 8'd0, 8'd0, ST_OK);
							b.res[1]  = mk_res(A_DONE, 8'd0, 8'd0, ST_NACK);
							nxt_phase = PH_IDLE;
						end else if (in_flags[F_ARB]) begin
							b.count   = 3'd2;
							b.res[0]  = mk_res(A_CLRARB, 8'd0, 8'd0, ST_OK);
							b.res[1]  = mk_res(A_DONE, 8'd0, 8'd0, ST_ARBLOST);
							nxt_phase = PH_IDLE;
						end else if (okbit) begin
							if (phase_q == PH_ADDR1) begin
								b.count   = 3'd2;
								b.res[0]  = mk_res(A_CLRADDR, 8'd0, 8'd0, ST_OK);
								b.res[1]  = mk_res(A_TX, reg_q, 8'd0, ST_OK);
								nxt_phase = PH_REG;
								nxt_cd    = timeout_q;
							end else if (phase_q == PH_ADDR2) begin
								b.res[0] = mk_res(A_CLRADDR, 8'd0, 8'd0, ST_OK);
								if (bl_q != 8'd0) begin
									b.count   = 3'd2;
									b.res[1]  = mk_res(A_ACK, 8'd0, 8'd0, ST_OK);
									nxt_phase = PH_RX;
									nxt_cd    = timeout_q;
								end else begin
									b.count   = 3'd4;
									b.res[1]  = mk_res(A_NACK, 8'd0, 8'd0, ST_OK);
									b.res[2]  = mk_res(A_STOP, 8'd0, 8'd0, ST_OK);
									b.res[3]  = mk_res(A_DONE, 8'd0, 8'd0, ST_OK);
									nxt_phase = PH_IDLE;
								end
							end else if (phase_q == PH_REG && rd_q) begin
								b.count   = 3'd2;
								b.res[0]  = mk_res(A_STOP, 8'd0, 8'd0, ST_OK);
								b.res[1]  = mk_res(A_START, 8'd0, 8'd0, ST_OK);
								nxt_phase = PH_START2;
								nxt_cd    = timeout_q;
							end else if (bl_q != 8'd0) begin
								b.count   = 3'd1;
								b.res[0]  = mk_res(A_REQ, 8'd0, bl_dec, ST_OK);
								nxt_phase = PH_DATA;
							end else begin
								b.count   = 3'd2;
								b.res[0]  = mk_res(A_STOP, 8'd0, 8'd0, ST_OK);
								b.res[1]  = mk_res(A_DONE, 8'd0, 8'd0, ST_OK);
								nxt_phase = PH_IDLE;
							end
						end
					end
					PH_RX: begin
						if (in_flags[F_RXNE] && bl_q != 8'd0) begin
							nxt_bl   = bl_dec;
							b.res[0] = mk_res(A_READ, in_data, bl_dec, ST_OK);
							if (bl_dec != 8'd0) begin
								b.count   = 3'd2;
								b.res[1]  = mk_res(A_ACK, 8'd0, 8'd0, ST_OK);
								nxt_cd    = timeout_q;
							end else begin
								b.count   = 3'd4;
								b.res[1]  = mk_res(A_NACK, 8'd0, 8'd0, ST_OK);
								b.res[2]  = mk_res(A_STOP, 8'd0, 8'd0, ST_OK);
								b.res[3]  = mk_res(A_DONE, 8'd0, 8'd0, ST_OK);
								nxt_phase = PH_IDLE;
							end
						end
					end
					default: begin
					end
				endcase
			end
			CMD_TICK: begin
				if (phase_q != PH_IDLE && phase_q != PH_DATA) begin
					if (cd_q == 8'd0) begin
						b.count   = 3'd2;
						b.res[0]  = mk_res(A_BUSRESET, 8'd0, 8'd0, ST_OK);
						b.res[1]  = mk_res(A_DONE, 8'd0, 8'd0, ST_TIMEOUT);
						nxt_phase = PH_IDLE;
					end else begin
						nxt_cd = cd_q - 8'd1;
					end
				end
			end
			CMD_WDATA: begin
				if (phase_q == PH_DATA && bl_q != 8'd0) begin
					nxt_bl    = bl_dec;
					b.count   = 3'd1;
					b.res[0]  = mk_res(A_TX, in_data, bl_dec, ST_OK);
					nxt_phase = PH_TXE;
					nxt_cd    = timeout_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign push      = accept && (b.count != 3'd0);
	assign push_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cd_q      <= 8'd0;
			bl_q      <= 8'd0;
			tgt_q     <= 7'd0;
			reg_q     <= 8'd0;
			rd_q      <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (accept) begin
				phase_q <= nxt_phase;
				cd_q    <= nxt_cd;
				bl_q    <= nxt_bl;
				tgt_q   <= nxt_tgt;
				reg_q   <= nxt_reg;
				rd_q    <= nxt_rd;
			end
		end
	end

endmodule

/* rtl/irts_queue.sv */
// ----------------------------------------------------------------------------
// irts_queue
// short queue of result bundles between sequencer and output side
// ----------------------------------------------------------------------------
module irts_queue import irts_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bundle_t                    push_data,
	output logic                       full,
	input  logic                       pop,
	output bundle_t                    pop_data,
	output logic                       empty,
	output logic [$clog2(Depth+1)-1:0] count
);

	localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth+1);

	bundle_t         mem_q [Depth];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CW'(Depth));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Depth-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Depth-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/irts_back.sv */
// ----------------------------------------------------------------------------
// irts_back
// unpacks result bundles into output beats, tlast on the final one
// ----------------------------------------------------------------------------
module irts_back import irts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     pop_data,
	input  logic        q_empty,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	bundle_t    bun_q;
	logic       have_q;
	logic [1:0] pos_q;
	logic       last_now;
	result_t    cur;

	assign last_now = ({1'b0, pos_q} == (bun_q.count - 3'd1));
	assign pop      = !q_empty && (!have_q || (m_axis_tready && last_now));
	assign cur      = bun_q.res[pos_q];

	assign m_axis_tvalid = have_q;
	assign m_axis_tdata  = {5'd0, cur.status, cur.index, cur.value};
	assign m_axis_tuser  = cur.action;
	assign m_axis_tlast  = last_now;

	always_ff @(posedge clk) begin
		if (pop) begin
			bun_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			pos_q  <= 2'd0;
		end else if (pop) begin
			have_q <= 1'b1;
			pos_q  <= 2'd0;
		end else if (have_q && m_axis_tready) begin
			if (last_now) begin
				have_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

endmodule
